### src/doubly_linked_list_table_macros.svh
// ----------------------------------------------------------------------------
// Doubly linked list table - assertion macros
// Concurrent property shorthands shared by the list table RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_TABLE_MACROS_SVH
`define DOUBLY_LINKED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/dllt_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list table - package
// Default sizes, sentinel positions and command / status codes.
// ----------------------------------------------------------------------------
package dllt_pkg;

   localparam int DEPTH_DEF       = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int HEAD_ENTRY = 1;
   localparam int TAIL_ENTRY = 2;
   localparam int FIRST_FREE = 3;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_QUERY  = 3'd2,
      CMD_MODIFY = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

endpackage

### src/doubly_linked_list_table.sv
// A doubly linked list kept in two single-port-write memories: a link memory
// holding each entry's predecessor and successor, and a value memory. Entry 1
// is the head sentinel, entry 2 the tail; new entries are handed out in order
// from entry 3 and never reclaimed but by a clear, which starts again at
// entry 3. Every request word yields one response word. After reset the block
// writes the head and then the tail sentinel before it raises req_ready. The
// link memory's single write port shapes the delete and insert sequences,
// since a splice needs two and three link writes after the registered read.
// One request is in flight at a time; a finished response waits in the output
// register, so the next request is taken while the previous response is
// still unclaimed.

// ----------------------------------------------------------------------------
// Doubly linked list table - top level
// Command decode, link/value memories, splice sequencer and response register.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_table_macros.svh"

module doubly_linked_list_table
   import dllt_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_cmd,
   input  logic [$clog2(DEPTH)-1:0]      req_node_index,
   input  logic [VALUE_WIDTH-1:0]        req_data_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(DEPTH)-1:0]      rsp_entry_index,
   output logic [$clog2(DEPTH)-1:0]      rsp_prev_index,
   output logic [$clog2(DEPTH)-1:0]      rsp_next_index,
   output logic [VALUE_WIDTH-1:0]        rsp_entry_value
);

   localparam int IdxW   = $clog2(DEPTH);
   localparam int AllocW = $clog2(DEPTH + 1);
   localparam int CmpW   = IdxW + 1;

   localparam logic [IdxW-1:0]   HeadIdx   = IdxW'(HEAD_ENTRY);
   localparam logic [IdxW-1:0]   TailIdx   = IdxW'(TAIL_ENTRY);
   localparam logic [AllocW-1:0] FirstFree = AllocW'(FIRST_FREE);
   localparam logic [AllocW-1:0] DepthCnt  = AllocW'(DEPTH);

   typedef struct packed {
      logic [IdxW-1:0] prev;
      logic [IdxW-1:0] next;
   } link_type;

   typedef enum logic [2:0] {
      ST_INIT_HEAD,
      ST_INIT_TAIL,
      ST_IDLE,
      ST_LOOKUP,
      ST_LINK_B,
      ST_LINK_NEW,
      ST_DONE
   } state_type;

   // memories
   link_type               link_mem  [DEPTH];
   logic [VALUE_WIDTH-1:0] value_mem [DEPTH];

   link_type               rd_link_ff;
   logic [VALUE_WIDTH-1:0] rd_val_ff;

   logic                   lw_prev_en;
   logic                   lw_next_en;
   logic [IdxW-1:0]        lw_addr;
   link_type               lw_link;
   logic                   vw_en;
   logic [IdxW-1:0]        vw_addr;
   logic [VALUE_WIDTH-1:0] vw_data;

   // sequencer state
   state_type              state_ff,   state_in;
   logic                   clr_pend_ff, clr_pend_in;
   logic [AllocW-1:0]      alloc_ff,   alloc_in;
   cmd_type                cmd_ff,     cmd_in;
   logic [IdxW-1:0]        idx_ff,     idx_in;
   logic [VALUE_WIDTH-1:0] data_ff,    data_in;
   link_type               lnk_ff,     lnk_in;
   logic [VALUE_WIDTH-1:0] eval_ff,    eval_in;

   // parked response
   status_type             park_status_ff, park_status_in;
   logic [IdxW-1:0]        park_entry_ff,  park_entry_in;
   logic [IdxW-1:0]        park_prev_ff,   park_prev_in;
   logic [IdxW-1:0]        park_next_ff,   park_next_in;
   logic [VALUE_WIDTH-1:0] park_value_ff,  park_value_in;

   // output register
   logic                   rsp_valid_ff,  rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [IdxW-1:0]        rsp_entry_ff,  rsp_entry_in;
   logic [IdxW-1:0]        rsp_prev_ff,   rsp_prev_in;
   logic [IdxW-1:0]        rsp_next_ff,   rsp_next_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff,  rsp_value_in;

   logic                   fin;
   status_type             fin_status;
   logic [IdxW-1:0]        fin_entry;
   logic [IdxW-1:0]        fin_prev;
   logic [IdxW-1:0]        fin_next;
   logic [VALUE_WIDTH-1:0] fin_value;

   logic                   slot_free;
   logic                   is_alloc;
   logic                   is_full;
   logic                   ins_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign is_alloc = (req_node_index != '0) &&
                     (CmpW'(req_node_index) < CmpW'(alloc_ff));
   assign is_full  = (alloc_ff >= DepthCnt);

   always_comb begin
      state_in       = state_ff;
      clr_pend_in    = clr_pend_ff;
      alloc_in       = alloc_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      data_in        = data_ff;
      lnk_in         = lnk_ff;
      eval_in        = eval_ff;
      park_status_in = park_status_ff;
      park_entry_in  = park_entry_ff;
      park_prev_in   = park_prev_ff;
      park_next_in   = park_next_ff;
      park_value_in  = park_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_prev_in    = rsp_prev_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_value_in   = rsp_value_ff;

      fin        = 1'b0;
      fin_status = STATUS_OK;
      fin_entry  = '0;
      fin_prev   = '0;
      fin_next   = '0;
      fin_value  = '0;
      ins_go     = 1'b0;

      lw_prev_en = 1'b0;
      lw_next_en = 1'b0;
      lw_addr    = '0;
      lw_link    = '0;
      vw_en      = 1'b0;
      vw_addr    = '0;
      vw_data    = '0;

      case (state_ff)
         ST_INIT_HEAD: begin
            lw_prev_en = 1'b1;
            lw_next_en = 1'b1;
            lw_addr    = HeadIdx;
            lw_link    = '{prev: '0, next: TailIdx};
            vw_en      = 1'b1;
            vw_addr    = HeadIdx;
            state_in   = ST_INIT_TAIL;
         end
         ST_INIT_TAIL: begin
            lw_prev_en  = 1'b1;
            lw_next_en  = 1'b1;
            lw_addr     = TailIdx;
            lw_link     = '{prev: HeadIdx, next: '0};
            vw_en       = 1'b1;
            vw_addr     = TailIdx;
            alloc_in    = FirstFree;
            clr_pend_in = 1'b0;
            state_in    = ST_IDLE;
            // a clear answers with an all-zero word; the reset pass does not
            fin         = clr_pend_ff;
         end
         ST_IDLE: begin
            if (req_valid) begin
               idx_in  = req_node_index;
               data_in = req_data_value;
               cmd_in  = cmd_type'(req_cmd);
               case (cmd_type'(req_cmd))
                  CMD_INSERT: begin
                     if (!is_alloc || req_node_index == TailIdx) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD;
                        fin_entry  = req_node_index;
                     end else if (is_full) begin
                        fin        = 1'b1;
                        fin_status = STATUS_FULL;
                        fin_entry  = req_node_index;
                     end else begin
                        ins_go   = 1'b1;
                        state_in = ST_LOOKUP;
                     end
                  end
                  CMD_DELETE: begin
                     if (!is_alloc || req_node_index == HeadIdx ||
                         req_node_index == TailIdx) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD;
                        fin_entry  = req_node_index;
                     end else begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  CMD_QUERY: begin
                     if (!is_alloc) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD;
                        fin_entry  = req_node_index;
                     end else begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  CMD_MODIFY: begin
                     if (!is_alloc) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BAD;
                        fin_entry  = req_node_index;
                     end else begin
                        vw_en    = 1'b1;
                        vw_addr  = req_node_index;
                        vw_data  = req_data_value;
                        state_in = ST_LOOKUP;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_pend_in = 1'b1;
                     state_in    = ST_INIT_HEAD;
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = STATUS_BAD;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  // successor's prev now points at the new entry
                  lnk_in       = rd_link_ff;
                  lw_prev_en   = 1'b1;
                  lw_addr      = rd_link_ff.next;
                  lw_link.prev = IdxW'(alloc_ff);
                  state_in     = ST_LINK_B;
               end
               CMD_DELETE: begin
                  lnk_in       = rd_link_ff;
                  eval_in      = rd_val_ff;
                  lw_next_en   = 1'b1;
                  lw_addr      = rd_link_ff.prev;
                  lw_link.next = rd_link_ff.next;
                  state_in     = ST_LINK_B;
               end
               CMD_MODIFY: begin
                  // value memory read raced the write: take the new word
                  fin       = 1'b1;
                  fin_entry = idx_ff;
                  fin_prev  = rd_link_ff.prev;
                  fin_next  = rd_link_ff.next;
                  fin_value = data_ff;
               end
               default: begin
                  fin       = 1'b1;
                  fin_entry = idx_ff;
                  fin_prev  = rd_link_ff.prev;
                  fin_next  = rd_link_ff.next;
                  fin_value = rd_val_ff;
               end
            endcase
         end
         ST_LINK_B: begin
            if (cmd_ff == CMD_INSERT) begin
               lw_next_en   = 1'b1;
               lw_addr      = idx_ff;
               lw_link.next = IdxW'(alloc_ff);
               state_in     = ST_LINK_NEW;
            end else begin
               lw_prev_en   = 1'b1;
               lw_addr      = lnk_ff.next;
               lw_link.prev = lnk_ff.prev;
               fin          = 1'b1;
               fin_entry    = idx_ff;
               fin_prev     = lnk_ff.prev;
               fin_next     = lnk_ff.next;
               fin_value    = eval_ff;
            end
         end
         ST_LINK_NEW: begin
            // new entry written last so a self-linked successor ends correct
            lw_prev_en = 1'b1;
            lw_next_en = 1'b1;
            lw_addr    = IdxW'(alloc_ff);
            lw_link    = '{prev: idx_ff, next: lnk_ff.next};
            vw_en      = 1'b1;
            vw_addr    = IdxW'(alloc_ff);
            vw_data    = data_ff;
            alloc_in   = alloc_ff + 1'b1;
            fin        = 1'b1;
            fin_entry  = IdxW'(alloc_ff);
            fin_prev   = idx_ff;
            fin_next   = lnk_ff.next;
            fin_value  = data_ff;
         end
         ST_DONE: begin
            fin        = 1'b1;
            fin_status = park_status_ff;
            fin_entry  = park_entry_ff;
            fin_prev   = park_prev_ff;
            fin_next   = park_next_ff;
            fin_value  = park_value_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the word to the output register, or park it while that is full
      if (fin) begin
         if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fin_status;
            rsp_entry_in  = fin_entry;
            rsp_prev_in   = fin_prev;
            rsp_next_in   = fin_next;
            rsp_value_in  = fin_value;
            state_in      = ST_IDLE;
         end else begin
            park_status_in = fin_status;
            park_entry_in  = fin_entry;
            park_prev_in   = fin_prev;
            park_next_in   = fin_next;
            park_value_in  = fin_value;
            state_in       = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_HEAD;
         clr_pend_ff  <= 1'b0;
         alloc_ff     <= FirstFree;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_pend_ff  <= clr_pend_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      data_ff        <= data_in;
      lnk_ff         <= lnk_in;
      eval_ff        <= eval_in;
      park_status_ff <= park_status_in;
      park_entry_ff  <= park_entry_in;
      park_prev_ff   <= park_prev_in;
      park_next_ff   <= park_next_in;
      park_value_ff  <= park_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_prev_ff    <= rsp_prev_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_value_ff   <= rsp_value_in;
   end

   // link memory: field-masked write, registered read
   always_ff @(posedge clock) begin
      if (lw_prev_en) begin
         link_mem[lw_addr].prev <= lw_link.prev;
      end
      if (lw_next_en) begin
         link_mem[lw_addr].next <= lw_link.next;
      end
      rd_link_ff <= link_mem[req_node_index];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (vw_en) begin
         value_mem[vw_addr] <= vw_data;
      end
      rd_val_ff <= value_mem[req_node_index];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_entry_ff;
   assign rsp_prev_index  = rsp_prev_ff;
   assign rsp_next_index  = rsp_next_ff;
   assign rsp_entry_value = rsp_value_ff;

   `DLLT_ASSERT_NOW(a_idle_no_link_write, clock, reset, req_ready, !(lw_prev_en || lw_next_en), "link memory written while idle")

   `DLLT_ASSERT_NEXT(a_park_when_blocked, clock, reset, fin && !slot_free, state_ff == ST_DONE && rsp_valid_ff, "finished word not parked behind a full output")

   `DLLT_ASSERT_NEXT(a_insert_bumps_alloc, clock, reset, ins_go, ##3 (alloc_ff == $past(alloc_ff, 4) + 1'b1), "insert did not advance the allocator by one")

endmodule

### dv/tb_doubly_linked_list_table.sv
// ----------------------------------------------------------------------------
// Doubly linked list table - testbench
// Drives list commands through the request handshake and mirrors the list in
// a scoreboard that predicts every response word. It covers a directed pass
// over the sentinel and index corner cases, then random traffic that grows
// the list until the allocator runs out. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_table;
   timeunit 1ns;
   timeprecision 1ps;

   import dllt_pkg::*;

   localparam int IDX_W         = $clog2(DEPTH_DEF);
   localparam int VAL_W         = VALUE_WIDTH_DEF;
   localparam int TOP_INDEX     = DEPTH_DEF - 1;
   localparam int CMD_CODES     = 1 << $bits(cmd_type);
   localparam int UNUSED_CMD_LO = int'(CMD_CLEAR) + 1;
   localparam int UNUSED_CMD_HI = CMD_CODES - 1;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] entry;
      logic [IDX_W-1:0] prev;
      logic [IDX_W-1:0] next;
      logic [VAL_W-1:0] value;
   } list_reply_type;

   class list_scoreboard;
      logic [IDX_W-1:0] prev_link [DEPTH_DEF];
      logic [IDX_W-1:0] next_link [DEPTH_DEF];
      logic [VAL_W-1:0] value_mem [DEPTH_DEF];
      int unsigned      alloc_next;
      list_reply_type   replies_due [$];
      int               errors;
      int               replies_seen;
      int               unknown_count;
      int               cmd_count [CMD_CODES];
      int               status_count [4];

      function new();
         foreach (prev_link[i]) begin
            prev_link[i] = '0;
            next_link[i] = '0;
            value_mem[i] = '0;
         end
         foreach (cmd_count[i]) cmd_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
         errors        = 0;
         replies_seen  = 0;
         unknown_count = 0;
         restore_sentinels();
      endfunction

      function void restore_sentinels();
         prev_link[HEAD_ENTRY] = '0;
         next_link[HEAD_ENTRY] = IDX_W'(TAIL_ENTRY);
         prev_link[TAIL_ENTRY] = IDX_W'(HEAD_ENTRY);
         next_link[TAIL_ENTRY] = '0;
         value_mem[HEAD_ENTRY] = '0;
         value_mem[TAIL_ENTRY] = '0;
         alloc_next            = FIRST_FREE;
      endfunction

      function bit in_use(int unsigned i);
         return i >= HEAD_ENTRY && i < alloc_next;
      endfunction

      // Update the mirrored list for one accepted request word and queue the
      // response it must produce.
      function void note_request(logic [2:0] cmd, logic [IDX_W-1:0] idx,
                                 logic [VAL_W-1:0] val);
         list_reply_type r;
         int unsigned n, s, a, b;
         bit          linked;
         r.status = STATUS_OK;
         r.entry  = idx;
         linked   = 1'b1;
         case (cmd)
            CMD_INSERT: begin
               // bad index wins over a full table
               if (!in_use(idx) || idx == TAIL_ENTRY) begin
                  r.status = STATUS_BAD;
                  linked   = 1'b0;
               end else if (alloc_next >= DEPTH_DEF) begin
                  r.status = STATUS_FULL;
                  linked   = 1'b0;
               end else begin
                  n              = alloc_next;
                  s              = next_link[idx];
                  value_mem[n]   = val;
                  next_link[n]   = IDX_W'(s);
                  prev_link[s]   = IDX_W'(n);
                  next_link[idx] = IDX_W'(n);
                  prev_link[n]   = idx;
                  alloc_next     = n + 1;
                  r.entry        = IDX_W'(n);
               end
            end
            CMD_DELETE: begin
               if (!in_use(idx) || idx == HEAD_ENTRY || idx == TAIL_ENTRY) begin
                  r.status = STATUS_BAD;
                  linked   = 1'b0;
               end else begin
                  // unlinked entry keeps its stale links
                  a            = prev_link[idx];
                  b            = next_link[idx];
                  next_link[a] = IDX_W'(b);
                  prev_link[b] = IDX_W'(a);
               end
            end
            CMD_QUERY: begin
               if (!in_use(idx)) begin
                  r.status = STATUS_BAD;
                  linked   = 1'b0;
               end
            end
            CMD_MODIFY: begin
               if (!in_use(idx)) begin
                  r.status = STATUS_BAD;
                  linked   = 1'b0;
               end else begin
                  value_mem[idx] = val;
               end
            end
            CMD_CLEAR: begin
               restore_sentinels();
               r.entry = '0;
               linked  = 1'b0;
            end
            default: begin
               r.status = STATUS_BAD;
               r.entry  = '0;
               linked   = 1'b0;
               unknown_count++;
            end
         endcase
         if (linked) begin
            r.prev  = prev_link[r.entry];
            r.next  = next_link[r.entry];
            r.value = value_mem[r.entry];
         end else begin
            r.prev  = '0;
            r.next  = '0;
            r.value = '0;
         end
         cmd_count[cmd]++;
         status_count[r.status]++;
         replies_due.insert(replies_due.size(), r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(input logic [1:0] status, input logic [IDX_W-1:0] entry,
                          input logic [IDX_W-1:0] prev, input logic [IDX_W-1:0] next,
                          input logic [VAL_W-1:0] value);
         list_reply_type r;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("response word with none outstanding, entry %0d",
                                      entry));
            return;
         end
         r = replies_due.pop_front();
         replies_seen++;
         if (status !== r.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      replies_seen, status, r.status));
         if (entry !== r.entry)
            report_mismatch($sformatf("word %0d entry %0d, want %0d",
                                      replies_seen, entry, r.entry));
         if (prev !== r.prev)
            report_mismatch($sformatf("word %0d prev %0d, want %0d",
                                      replies_seen, prev, r.prev));
         if (next !== r.next)
            report_mismatch($sformatf("word %0d next %0d, want %0d",
                                      replies_seen, next, r.next));
         if (value !== r.value)
            report_mismatch($sformatf("word %0d value %h, want %h",
                                      replies_seen, value, r.value));
      endtask
   endclass

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [2:0]       req_cmd        = '0;
   logic [IDX_W-1:0] req_node_index = '0;
   logic [VAL_W-1:0] req_data_value = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [1:0]       rsp_status;
   logic [IDX_W-1:0] rsp_entry_index;
   logic [IDX_W-1:0] rsp_prev_index;
   logic [IDX_W-1:0] rsp_next_index;
   logic [VAL_W-1:0] rsp_entry_value;

   int               snd_idle_pct = 0;
   int               rcv_idle_pct = 0;
   list_scoreboard   sb;

   doubly_linked_list_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_node_index  (req_node_index),
      .req_data_value  (req_data_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_prev_index  (rsp_prev_index),
      .rsp_next_index  (rsp_next_index),
      .rsp_entry_value (rsp_entry_value)
   );

   always #4 clock = ~clock;

   // response side: check on handshake, then pick next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_entry_index, rsp_prev_index,
                              rsp_next_index, rsp_entry_value);
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Called just after a rising edge; returns just after the accepting edge.
   task automatic send_word(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_node_index <= idx;
      req_data_value <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, idx, val);
   endtask

   // Hold off requests until every outstanding response has been claimed.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.replies_due.size() != 0);
   endtask

   // Mostly addresses entries in use; a few words go anywhere in the table.
   task automatic run_phase(int n_min, int n_max, int insert_pct, bit allow_clear,
                            int full_target);
      int               k;
      int               r;
      logic [2:0]       cmd;
      logic [IDX_W-1:0] idx;
      k = 0;
      while (k < n_max && (k < n_min || sb.status_count[STATUS_FULL] < full_target)) begin
         r = $urandom_range(99);
         if (r < insert_pct) begin
            cmd = CMD_INSERT;
         end else begin
            r = $urandom_range(99);
            if (r < 28)
               cmd = CMD_DELETE;
            else if (r < 56)
               cmd = CMD_QUERY;
            else if (r < 84)
               cmd = CMD_MODIFY;
            else if (r < 92)
               cmd = allow_clear ? CMD_CLEAR : CMD_QUERY;
            else
               cmd = 3'($urandom_range(UNUSED_CMD_LO, UNUSED_CMD_HI));
         end
         if ($urandom_range(99) < 8)
            idx = IDX_W'($urandom);
         else
            idx = IDX_W'($urandom_range(HEAD_ENTRY, sb.alloc_next - 1));
         send_word(cmd, idx, VAL_W'($urandom));
         k++;
      end
   endtask

   initial begin
      sb           = new();
      snd_idle_pct = 36;
      rcv_idle_pct = 51;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sentinels, out-of-range indexes and forbidden targets
      send_word(CMD_QUERY,  IDX_W'(HEAD_ENTRY), '0);
      send_word(CMD_QUERY,  IDX_W'(TAIL_ENTRY), '0);
      send_word(CMD_QUERY,  '0, '0);
      send_word(CMD_QUERY,  IDX_W'(TOP_INDEX), '0);
      send_word(CMD_INSERT, IDX_W'(TAIL_ENTRY), {VAL_W{1'b1}});
      send_word(CMD_DELETE, IDX_W'(HEAD_ENTRY), '0);
      send_word(CMD_DELETE, IDX_W'(TAIL_ENTRY), '0);
      send_word(CMD_INSERT, IDX_W'(HEAD_ENTRY), {VAL_W{1'b1}});
      send_word(CMD_INSERT, IDX_W'(FIRST_FREE), '0);
      send_word(CMD_INSERT, IDX_W'(HEAD_ENTRY), 32'h5a5a_5a5a);
      send_word(CMD_MODIFY, IDX_W'(FIRST_FREE + 1), 32'ha5a5_a5a5);
      send_word(CMD_DELETE, IDX_W'(FIRST_FREE), '0);
      send_word(CMD_QUERY,  IDX_W'(FIRST_FREE), '0);
      // splice after an entry that has already been unlinked
      send_word(CMD_INSERT, IDX_W'(FIRST_FREE), 32'h1234_5678);
      send_word(CMD_DELETE, IDX_W'(TOP_INDEX), '0);
      send_word(CMD_MODIFY, IDX_W'(TOP_INDEX), {VAL_W{1'b1}});
      send_word(CMD_MODIFY, '0, '0);
      for (int c = UNUSED_CMD_LO; c <= UNUSED_CMD_HI; c++)
         send_word(3'(c), IDX_W'(TOP_INDEX), {VAL_W{1'b1}});
      send_word(CMD_CLEAR,  IDX_W'(TOP_INDEX), {VAL_W{1'b1}});
      send_word(CMD_QUERY,  IDX_W'(FIRST_FREE), '0);
      send_word(CMD_QUERY,  IDX_W'(HEAD_ENTRY), '0);
      send_word(CMD_INSERT, IDX_W'(HEAD_ENTRY), 32'h8000_0001);
      send_word(CMD_DELETE, IDX_W'(FIRST_FREE), '0);

      run_phase(300, 300, 35, 1'b1, 0);
      wait_drained();

      snd_idle_pct = 51;
      rcv_idle_pct = 36;
      run_phase(400, 400, 88, 1'b0, 0);

      // no idling; keep inserting until the allocator is exhausted
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_phase(300, 1500, 88, 1'b0, 30);
      send_word(CMD_CLEAR,  '0, '0);
      send_word(CMD_INSERT, IDX_W'(HEAD_ENTRY), VAL_W'($urandom));
      send_word(CMD_QUERY,  IDX_W'(FIRST_FREE), '0);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d words: %0d insert, %0d delete, %0d query, %0d modify, %0d clear,",
               sb.replies_seen, sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_DELETE],
               sb.cmd_count[CMD_QUERY], sb.cmd_count[CMD_MODIFY],
               sb.cmd_count[CMD_CLEAR]);
      $display("%0d unknown; statuses %0d ok, %0d table full, %0d bad index; %0d mismatches",
               sb.unknown_count, sb.status_count[STATUS_OK],
               sb.status_count[STATUS_FULL], sb.status_count[STATUS_BAD], sb.errors);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
